>>> rtl/core/sht_pkg.sv
package sht_pkg;

	// Table geometry
	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int SLOT_W      = IDX_W + 1;
	localparam int KEY_W       = 64;
	localparam int OFF_W       = 24;
	localparam int ADDR_W      = 32;
	localparam int CMD_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD_KEY = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_OFF = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRINGS_BASE = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_OFF0,
		ST_OFF1,
		ST_HIT,
		ST_MISS
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic key_rd;
		logic step;
		logic off_rd;
		logic off_sel;
		logic off0_cap;
		logic out_load;
		logic out_hit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic trivial;
		logic match;
		logic last;
	} dp_status_t;

endpackage

>>> rtl/core/sht_dpath.sv
module sht_dpath import sht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             ctl,
	output dp_status_t            sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [KEY_W-1:0]      search_key,
	input  logic [OFF_W-1:0]      string_offset,
	output logic                  found,
	output logic [IDX_W-1:0]      hit_index,
	output logic [ADDR_W-1:0]     string_address,
	output logic [OFF_W-1:0]      string_length
);

	logic [SLOT_W-1:0] entry_count_q;
	logic [ADDR_W-1:0] strings_base_q;
	logic [SLOT_W-1:0] n_used;
	logic [KEY_W-1:0]  key_q;
	logic [ADDR_W-1:0] base_q;
	logic [SLOT_W-1:0] lo_q;
	logic [SLOT_W-1:0] hix_q;
	logic [SLOT_W:0]   mid_sum;
	logic [IDX_W-1:0]  mid;
	logic [SLOT_W-1:0] mid_ext;
	logic [SLOT_W-1:0] next_lo;
	logic [SLOT_W-1:0] next_hix;
	logic              less;
	logic [KEY_W-1:0]  key_rd_q;
	logic [OFF_W-1:0]  off_rd_q;
	logic [OFF_W-1:0]  off0_q;
	logic [SLOT_W-1:0] off_addr;
	logic              key_we;
	logic              off_we;

	logic [KEY_W-1:0]  key_mem [MAX_ENTRIES];
	logic [OFF_W-1:0]  off_mem [MAX_ENTRIES+1];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q  <= '0;
			strings_base_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_COUNT:  entry_count_q  <= cfg_data[SLOT_W-1:0];
				REG_STRINGS_BASE: strings_base_q <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the key count to the table depth
	always_comb begin
		if (entry_count_q > SLOT_W'(MAX_ENTRIES))
			n_used = SLOT_W'(MAX_ENTRIES);
		else
			n_used = entry_count_q;
	end

	// Search window [lo, hix) and its midpoint
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hix_q} - (SLOT_W+1)'(1);
	assign mid      = mid_sum[IDX_W:1];
	assign mid_ext  = SLOT_W'(mid);
	assign less     = key_rd_q < key_q;
	assign next_lo  = less ? mid_ext + SLOT_W'(1) : lo_q;
	assign next_hix = less ? hix_q : mid_ext;

	assign sts.trivial = (search_key == '0) || (n_used == '0);
	assign sts.match   = key_rd_q == key_q;
	assign sts.last    = !(next_lo < next_hix);

	// Capture the lookup and narrow the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q  <= '0;
			hix_q <= '0;
		end else if (ctl.accept) begin
			lo_q  <= '0;
			hix_q <= n_used;
		end else if (ctl.step) begin
			lo_q  <= next_lo;
			hix_q <= next_hix;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			key_q  <= search_key;
			base_q <= strings_base_q + ADDR_W'({n_used + SLOT_W'(1), 2'b00});
		end
	end

	// Key memory
	assign key_we = ctl.accept && (cmd == CMD_LOAD_KEY) && (slot < SLOT_W'(MAX_ENTRIES));

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[slot[IDX_W-1:0]] <= search_key;
		if (ctl.key_rd)
			key_rd_q <= key_mem[mid];
	end

	// Offset memory
	assign off_we   = ctl.accept && (cmd == CMD_LOAD_OFF) && (slot <= SLOT_W'(MAX_ENTRIES));
	assign off_addr = ctl.off_sel ? mid_ext + SLOT_W'(1) : mid_ext;

	always_ff @(posedge clk) begin
		if (off_we)
			off_mem[slot] <= string_offset;
		if (ctl.off_rd)
			off_rd_q <= off_mem[off_addr];
		if (ctl.off0_cap)
			off0_q <= off_rd_q;
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			if (ctl.out_hit) begin
				found          <= 1'b1;
				hit_index      <= mid;
				string_address <= base_q + ADDR_W'(off0_q);
				string_length  <= off_rd_q - off0_q;
			end else begin
				found          <= 1'b0;
				hit_index      <= '0;
				string_address <= '0;
				string_length  <= '0;
			end
		end
	end

endmodule

>>> rtl/core/sht_ctrl.sv
module sht_ctrl import sht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] cmd,
	output logic             out_valid,
	input  logic             out_ready,
	input  dp_status_t       sts,
	output ctrl_cmd_t        ctl
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Output slot: fill on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					if (cmd == CMD_LOOKUP && !sts.trivial)
						state_d = ST_PROBE;
					else
						state_d = ST_MISS;
				end
			end
			ST_PROBE: begin
				ctl.key_rd = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				if (sts.match) begin
					state_d = ST_OFF0;
				end else begin
					ctl.step = 1'b1;
					state_d  = sts.last ? ST_MISS : ST_PROBE;
				end
			end
			ST_OFF0: begin
				ctl.off_rd = 1'b1;
				state_d    = ST_OFF1;
			end
			ST_OFF1: begin
				ctl.off0_cap = 1'b1;
				ctl.off_rd   = 1'b1;
				ctl.off_sel  = 1'b1;
				state_d      = ST_HIT;
			end
			ST_HIT: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_hit  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_MISS: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/core/sorted_hash_table_lookup.sv
// Binary-search lookup over one page of ascending 64-bit hash keys, with a
// companion table of entry_count+1 string offsets. Every command gives one
// result: load commands write one table entry and return all zeros, a lookup
// returns found, index, string address and string length. One command is in
// work at a time. A load, or a lookup of a zero key or on an empty page, goes
// from IDLE straight to MISS and back to IDLE. A search repeats PROBE and CMP
// once per probe, then ends in MISS, or on a hit runs OFF0, OFF1 and HIT; it
// makes at most 11 probes for 1024 keys. Each probe is a synchronous read of
// the key memory followed by a compare; a hit adds two reads of the offset
// memory. A finished result waits in the output register while the next
// command is accepted; a result that cannot leave holds the block in its last
// state until the output register frees. Tables have no reset; reading an
// entry never written gives undefined fields. Configuration is taken in every
// cycle.
module sorted_hash_table_lookup import sht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [KEY_W-1:0]      search_key,
	input  logic [OFF_W-1:0]      string_offset,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  found,
	output logic [IDX_W-1:0]      hit_index,
	output logic [ADDR_W-1:0]     string_address,
	output logic [OFF_W-1:0]      string_length
);

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	sht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	sht_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.slot           (slot),
		.search_key     (search_key),
		.string_offset  (string_offset),
		.found          (found),
		.hit_index      (hit_index),
		.string_address (string_address),
		.string_length  (string_length)
	);

	// Block goes busy right after taking a command
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted command");

	// A new result only appears when a command was in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a command in work");

	// A miss carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> hit_index == '0 && string_address == '0 &&
			string_length == '0)
		else $error("not-found result carries nonzero fields");

endmodule
